### design/arsl_pkg.sv
`timescale 1ns / 1ps
package arsl_pkg;

  localparam int ADDR_W   = 64;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 3;
  localparam int HIDX_W   = 10;
  localparam int HELD_W   = 11;

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_GUESS    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

  // One table row as stored in the entry RAM.
  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] length;
    logic              is_func;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

### design/arsl_ram.sv
`timescale 1ns / 1ps
module arsl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### design/address_range_symbol_lookup_top.sv
`timescale 1ns / 1ps
// Sorted address-range table with interval lookup.
// Input channel (in_*): one transaction per item. in_action selects clear,
// append (in_entry_* fields) or lookup (in_query_address). Output channel
// (out_*): exactly one result transaction per accepted item, in order.
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Appends must arrive in ascending start order; an append below
// the last stored start, or into a full table, is answered as rejected.
// A clear, an append or the unused code goes from acceptance straight to
// the emit state. A lookup runs B binary search probes, then up to S
// backward scan steps; B is at most ceil(log2(entries+1)), 11 for 1024
// entries, and S at most SCAN_LIMIT. A covered hit ends the scan. Each
// probe and scan step is a read of the entry RAM followed by a compare.
// One item is in flight at a time: in_stall is low only while the engine
// is idle; the next item can be taken while the previous result still sits
// in the output register.
// If the receiver stalls, the result holds in the output register and a
// finished item waits in its emit state until that register drains.
// Reset (rst_n low, synchronous) empties the table and drops any result;
// the RAM contents are not cleared and are never read beyond the fill count.
module address_range_symbol_lookup_top #(
  parameter int TABLE_DEPTH = 1024,
  parameter int SCAN_LIMIT  = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [arsl_pkg::ACTION_W-1:0] in_action,
  input  logic [arsl_pkg::ADDR_W-1:0]   in_entry_start,
  input  logic [arsl_pkg::ADDR_W-1:0]   in_entry_length,
  input  logic                          in_entry_is_function,
  input  logic [arsl_pkg::ADDR_W-1:0]   in_query_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [arsl_pkg::STATUS_W-1:0] out_status,
  output logic [arsl_pkg::HIDX_W-1:0]   out_hit_index,
  output logic [arsl_pkg::ADDR_W-1:0]   out_hit_start,
  output logic [arsl_pkg::ADDR_W-1:0]   out_hit_length,
  output logic                          out_hit_is_function,
  output logic [arsl_pkg::HELD_W-1:0]   out_entries_held
);

  import arsl_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);        // RAM index
  localparam int CW = $clog2(TABLE_DEPTH + 1);    // fill count, search bounds
  localparam int SW = $clog2(SCAN_LIMIT + 1);     // scan step counter
  localparam int XW = (IW > HIDX_W) ? IW : HIDX_W;
  localparam int HW = (CW > HELD_W) ? CW : HELD_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_RD,   // issue a binary search probe
    S_BS_CMP,  // narrow bounds with the probe data
    S_SC_RD,   // issue a backward scan read
    S_SC_CMP,  // test coverage / remember a guess
    S_EMIT     // hand the result to the output register
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [ADDR_W-1:0] last_start_r, last_start_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     mid_r, mid_nxt;
  logic [CW-1:0]     pos_r, pos_nxt;
  logic [SW-1:0]     chk_r, chk_nxt;
  logic              have_guess_r, have_guess_nxt;
  logic [IW-1:0]     guess_idx_r, guess_idx_nxt;
  entry_t            guess_ent_r, guess_ent_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [IW-1:0]     res_idx_r, res_idx_nxt;
  entry_t            res_ent_r, res_ent_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [HIDX_W-1:0]   out_idx_r, out_idx_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic [HELD_W-1:0]   out_held_r, out_held_nxt;

  logic          ram_wr_en;
  logic [IW-1:0] ram_wr_addr;
  entry_t        ram_wr_data;
  logic          ram_rd_en;
  logic [IW-1:0] ram_rd_addr;
  entry_t        ram_rd_data;

  logic          in_take;
  logic          out_free;
  logic [CW-1:0] mid_calc;
  logic [CW-1:0] pos_dec;
  logic [ADDR_W-1:0] offset;
  logic [XW-1:0] idx_ext;
  logic [HW-1:0] held_ext;
  entry_t        new_ent;

  arsl_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign mid_calc = lo_r + ((hi_r - lo_r) >> 1);
  assign pos_dec  = pos_r - CW'(1);
  // The scan reaches only entries starting at or below addr, so this never wraps.
  assign offset   = addr_r - ram_rd_data.start;
  assign idx_ext  = XW'(res_idx_r);
  assign held_ext = HW'(count_r);

  assign new_ent.start   = in_entry_start;
  assign new_ent.length  = in_entry_length;
  assign new_ent.is_func = in_entry_is_function;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    last_start_nxt = last_start_r;
    addr_nxt       = addr_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    pos_nxt        = pos_r;
    chk_nxt        = chk_r;
    have_guess_nxt = have_guess_r;
    guess_idx_nxt  = guess_idx_r;
    guess_ent_nxt  = guess_ent_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_ent_nxt    = out_ent_r;
    out_held_nxt   = out_held_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = count_r[IW-1:0];
    ram_wr_data    = new_ent;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = mid_calc[IW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          state_nxt   = S_EMIT;
          res_idx_nxt = '0;
          res_ent_nxt = '0;
          unique case (in_action)
            ACT_CLEAR: begin
              count_nxt      = '0;
              res_status_nxt = ST_CLEARED;
            end
            ACT_APPEND: begin
              if (count_r >= CW'(TABLE_DEPTH) ||
                  (count_r != '0 && in_entry_start < last_start_r)) begin
                res_status_nxt = ST_REJECTED;
              end else begin
                ram_wr_en      = 1'b1;
                count_nxt      = count_r + CW'(1);
                last_start_nxt = in_entry_start;
                res_status_nxt = ST_APPENDED;
                res_idx_nxt    = count_r[IW-1:0];
                res_ent_nxt    = new_ent;
              end
            end
            ACT_LOOKUP: begin
              addr_nxt  = in_query_address;
              lo_nxt    = '0;
              hi_nxt    = count_r;
              state_nxt = S_BS_RD;
            end
            default: begin
              res_status_nxt = ST_NOTFOUND;
            end
          endcase
        end
      end

      S_BS_RD: begin
        if (lo_r < hi_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = mid_calc[IW-1:0];
          mid_nxt     = mid_calc;
          state_nxt   = S_BS_CMP;
        end else begin
          // lo is the upper bound: count of entries starting at or below addr.
          pos_nxt        = lo_r;
          chk_nxt        = '0;
          have_guess_nxt = 1'b0;
          state_nxt      = S_SC_RD;
        end
      end

      S_BS_CMP: begin
        if (addr_r < ram_rd_data.start) begin
          hi_nxt = mid_r;
        end else begin
          lo_nxt = mid_r + CW'(1);
        end
        state_nxt = S_BS_RD;
      end

      S_SC_RD: begin
        if (pos_r != '0 && chk_r < SW'(SCAN_LIMIT)) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pos_dec[IW-1:0];
          pos_nxt     = pos_dec;
          chk_nxt     = chk_r + SW'(1);
          state_nxt   = S_SC_CMP;
        end else begin
          if (have_guess_r) begin
            res_status_nxt = ST_GUESS;
            res_idx_nxt    = guess_idx_r;
            res_ent_nxt    = guess_ent_r;
          end else begin
            res_status_nxt = ST_NOTFOUND;
            res_idx_nxt    = '0;
            res_ent_nxt    = '0;
          end
          state_nxt = S_EMIT;
        end
      end

      S_SC_CMP: begin
        if (offset < ram_rd_data.length) begin
          res_status_nxt = ST_HIT;
          res_idx_nxt    = pos_r[IW-1:0];
          res_ent_nxt    = ram_rd_data;
          state_nxt      = S_EMIT;
        end else begin
          // Nearest zero-length function entry is the first one met.
          if (!have_guess_r && ram_rd_data.length == '0 && ram_rd_data.is_func) begin
            have_guess_nxt = 1'b1;
            guess_idx_nxt  = pos_r[IW-1:0];
            guess_ent_nxt  = ram_rd_data;
          end
          state_nxt = S_SC_RD;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_idx_nxt    = idx_ext[HIDX_W-1:0];
          out_ent_nxt    = res_ent_r;
          out_held_nxt   = held_ext[HELD_W-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    last_start_r <= last_start_nxt;
    addr_r       <= addr_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    pos_r        <= pos_nxt;
    chk_r        <= chk_nxt;
    have_guess_r <= have_guess_nxt;
    guess_idx_r  <= guess_idx_nxt;
    guess_ent_r  <= guess_ent_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_ent_r    <= out_ent_nxt;
    out_held_r   <= out_held_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_hit_index       = out_idx_r;
  assign out_hit_start       = out_ent_r.start;
  assign out_hit_length      = out_ent_r.length;
  assign out_hit_is_function = out_ent_r.is_func;
  assign out_entries_held    = out_held_r;

  // Fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Search window stays ordered and inside the filled part of the table.
  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BS_RD || state_r == S_BS_CMP) |-> (lo_r <= hi_r && hi_r <= count_r))
    else $error("binary search bounds out of order");

  // Each scan compare follows a read, within the step limit, below the fill count.
  a_scan_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SC_CMP |-> (chk_r != '0 && chk_r <= SW'(SCAN_LIMIT) && pos_r < count_r))
    else $error("scan step out of range");

  // An accepted transaction always occupies the engine on the next cycle.
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != S_IDLE)
    else $error("accepted transaction dropped");

endmodule

### tb/sv/address_range_symbol_lookup_top_test.sv
`timescale 1ns / 1ps
module address_range_symbol_lookup_top_test;
  import arsl_pkg::*;

  // Table geometry the DUT is built with (defaults)
  localparam int DEPTH       = 1024;
  localparam int SCAN_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 420;
  localparam int QUIET_TAIL   = 60;    // last transactions run without idling
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int DRAIN_CYCLES = 150;   // extra wait after the last expected result

  // Action code the package leaves unnamed; the block answers it as not found
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0]   MAX64      = '1;

  // One input transaction
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [ADDR_W-1:0]   start;
    logic [ADDR_W-1:0]   length;
    logic                is_func;
    logic [ADDR_W-1:0]   addr;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [HIDX_W-1:0]   index;
    logic [ADDR_W-1:0]   start;
    logic [ADDR_W-1:0]   length;
    logic                is_func;
    logic [HELD_W-1:0]   held;
  } result_t;

  // Directed row: stimulus plus, where obvious, the hand-written answer
  typedef struct {
    item_t   stim;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ACTION_W-1:0] in_action;
  logic [ADDR_W-1:0]   in_entry_start;
  logic [ADDR_W-1:0]   in_entry_length;
  logic                in_entry_is_function;
  logic [ADDR_W-1:0]   in_query_address;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [HIDX_W-1:0]   out_hit_index;
  logic [ADDR_W-1:0]   out_hit_start;
  logic [ADDR_W-1:0]   out_hit_length;
  logic                out_hit_is_function;
  logic [HELD_W-1:0]   out_entries_held;

  // Shadow copy of the interval table
  logic [ADDR_W-1:0] tbl_start [DEPTH];
  logic [ADDR_W-1:0] tbl_len   [DEPTH];
  logic              tbl_func  [DEPTH];
  int                tbl_count = 0;

  result_t  pending_results[$];
  dir_row_t dir_table[$];

  int  mismatch_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  int  stall_left = 0;
  int  outcome_tally[8];
  bit  idle_mode = 1'b1;

  address_range_symbol_lookup_top DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_action           (in_action),
    .in_entry_start      (in_entry_start),
    .in_entry_length     (in_entry_length),
    .in_entry_is_function(in_entry_is_function),
    .in_query_address    (in_query_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_hit_index       (out_hit_index),
    .out_hit_start       (out_hit_start),
    .out_hit_length      (out_hit_length),
    .out_hit_is_function (out_hit_is_function),
    .out_entries_held    (out_entries_held)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d results outstanding",
               $time, pending_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Table predictor. Applies one transaction to the shadow table and returns
  // the result the block must give. The scan start is the count of entries
  // whose start is at or below the address; since the table is sorted, a walk
  // down from the top finds the same point.
  // ---------------------------------------------------------------------------
  function automatic result_t apply_to_table(input item_t it);
    result_t r;
    int      pos;
    int      scanned;
    int      guess;
    int      pick;
    r = '0;
    pick = -1;
    case (it.action)
      ACT_CLEAR: begin
        tbl_count = 0;              // stores keep stale data, never read
        r.status = ST_CLEARED;
      end
      ACT_APPEND: begin
        if (tbl_count == DEPTH ||
            (tbl_count > 0 && it.start < tbl_start[tbl_count-1])) begin
          r.status = ST_REJECTED;
        end else begin
          tbl_start[tbl_count] = it.start;
          tbl_len[tbl_count]   = it.length;
          tbl_func[tbl_count]  = it.is_func;
          pick = tbl_count;
          tbl_count++;
          r.status = ST_APPENDED;
        end
      end
      ACT_LOOKUP: begin
        pos = tbl_count;
        while (pos > 0 && tbl_start[pos-1] > it.addr) pos--;
        scanned = 0;
        guess = -1;
        r.status = ST_NOTFOUND;
        // walk back at most SCAN_DEPTH entries; the first cover wins, and the
        // nearest zero-length function seen on the way is kept as a guess
        while (pick < 0 && pos > 0 && scanned < SCAN_DEPTH) begin
          pos--;
          scanned++;
          if (it.addr - tbl_start[pos] < tbl_len[pos]) begin
            pick = pos;
            r.status = ST_HIT;
          end else if (guess < 0 && tbl_len[pos] == '0 && tbl_func[pos]) begin
            guess = pos;
          end
        end
        if (pick < 0 && guess >= 0) begin
          pick = guess;
          r.status = ST_GUESS;
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
      end
    endcase
    if (pick >= 0) begin
      r.index   = pick[HIDX_W-1:0];
      r.start   = tbl_start[pick];
      r.length  = tbl_len[pick];
      r.is_func = tbl_func[pick];
    end
    r.held = tbl_count[HELD_W-1:0];
    return r;
  endfunction

  function automatic item_t mk_item(input logic [ACTION_W-1:0] act,
                                    input logic [ADDR_W-1:0] s,
                                    input logic [ADDR_W-1:0] l,
                                    input logic f,
                                    input logic [ADDR_W-1:0] q);
    item_t it;
    it.action = act;
    it.start = s;
    it.length = l;
    it.is_func = f;
    it.addr = q;
    return it;
  endfunction

  function automatic result_t mk_result(input logic [STATUS_W-1:0] st,
                                        input logic [HIDX_W-1:0] idx,
                                        input logic [ADDR_W-1:0] s,
                                        input logic [ADDR_W-1:0] l,
                                        input logic f,
                                        input logic [HELD_W-1:0] held);
    result_t r;
    r.status = st;
    r.index = idx;
    r.start = s;
    r.length = l;
    r.is_func = f;
    r.held = held;
    return r;
  endfunction

  function automatic void typed_row(input item_t it, input result_t want);
    dir_row_t row;
    row.stim = it;
    row.typed = 1'b1;
    row.want = want;
    dir_table.insert(dir_table.size(), row);
  endfunction

  function automatic void model_row(input item_t it);
    dir_row_t row;
    row.stim = it;
    row.typed = 1'b0;
    row.want = '0;
    dir_table.insert(dir_table.size(), row);
  endfunction

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Start for the next in-order append: mostly small steps, some equal starts,
  // some wide jumps; saturates at the top of the address space
  function automatic logic [ADDR_W-1:0] next_entry_start();
    logic [ADDR_W-1:0] step;
    logic [ADDR_W:0]   sum;
    if (tbl_count == 0) begin
      return ($urandom_range(0, 3) == 0) ? '0 : rand64() >> $urandom_range(0, 63);
    end
    case ($urandom_range(0, 9))
      0:       step = '0;
      7, 8:    step = {32'd0, $urandom()};
      9:       step = rand64() >> 8;
      default: step = ADDR_W'($urandom_range(1, 256));
    endcase
    sum = {1'b0, tbl_start[tbl_count-1]} + {1'b0, step};
    return sum[ADDR_W] ? MAX64 : sum[ADDR_W-1:0];
  endfunction

  // Lengths lean toward zero so guesses and scan exhaustion come up often
  function automatic logic [ADDR_W-1:0] pick_length();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return '0;
      7:          return {32'd0, $urandom()};
      8:          return rand64();
      9:          return MAX64;
      default:    return ADDR_W'($urandom_range(1, 512));
    endcase
  endfunction

  // Query addresses clustered around entry boundaries
  function automatic logic [ADDR_W-1:0] pick_query();
    int k;
    if (tbl_count == 0) return rand64();
    k = $urandom_range(0, tbl_count - 1);
    case ($urandom_range(0, 9))
      0, 1:    return tbl_start[k];
      2, 3:    return tbl_start[k] + tbl_len[k] - 1;
      4:       return tbl_start[k] + tbl_len[k];
      5, 6:    return tbl_start[k] + ADDR_W'($urandom_range(0, 600));
      7:       return rand64();
      8:       return $urandom_range(0, 1) ? '0 : MAX64;
      default: return tbl_start[0] - 1;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Send one transaction. While idling is on, an optional gap with in_valid
  // low may precede it; the payload changes at the falling edge and is held
  // until accepted. The expected result is queued at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic drive_item(input item_t it, input bit typed, input result_t want);
    int      gap;
    result_t predicted;
    if (idle_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid             = 1'b1;
    in_action            = it.action;
    in_entry_start       = it.start;
    in_entry_length      = it.length;
    in_entry_is_function = it.is_func;
    in_query_address     = it.addr;
    do @(posedge clk); while (in_stall);
    predicted = apply_to_table(it);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
    items_sent++;
  endtask

  task automatic send_lookup();
    drive_item(mk_item(ACT_LOOKUP, rand64(), rand64(), 1'($urandom_range(0, 1)),
                       pick_query()), 1'b0, '0);
  endtask

  task automatic send_append(input logic [ADDR_W-1:0] len, input logic f);
    drive_item(mk_item(ACT_APPEND, next_entry_start(), len, f, rand64()), 1'b0, '0);
  endtask

  task automatic send_clear();
    drive_item(mk_item(ACT_CLEAR, rand64(), rand64(), 1'($urandom_range(0, 1)), rand64()),
               1'b0, '0);
  endtask

  // Receiver: random stall bursts, started only while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if (idle_mode && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic check_field(input string name, input logic [ADDR_W-1:0] want,
                             input logic [ADDR_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d index %0d",
                 $time, out_status, out_hit_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", ADDR_W'(want.status), ADDR_W'(out_status));
        check_field("hit_index", ADDR_W'(want.index), ADDR_W'(out_hit_index));
        check_field("hit_start", want.start, out_hit_start);
        check_field("hit_length", want.length, out_hit_length);
        check_field("hit_is_function", ADDR_W'(want.is_func),
                    ADDR_W'(out_hit_is_function));
        check_field("entries_held", ADDR_W'(want.held), ADDR_W'(out_entries_held));
        outcome_tally[want.status]++;
      end
    end
  end

  initial begin
    logic [ADDR_W-1:0] below;
    int random_base;
    int mixed;
    int n;
    in_valid             = 1'b0;
    in_action            = ACT_CLEAR;
    in_entry_start       = '0;
    in_entry_length      = '0;
    in_entry_is_function = 1'b0;
    in_query_address     = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // ---- directed part ----
    // empty table and the unused action code
    typed_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, '0),
              mk_result(ST_NOTFOUND, '0, '0, '0, 1'b0, 11'd0));
    typed_row(mk_item(ACT_UNUSED, MAX64, MAX64, 1'b1, MAX64),
              mk_result(ST_NOTFOUND, '0, '0, '0, 1'b0, 11'd0));
    // zero-length function at address 0 acts as the fallback guess
    typed_row(mk_item(ACT_APPEND, '0, '0, 1'b1, '0),
              mk_result(ST_APPENDED, 10'd0, '0, '0, 1'b1, 11'd1));
    typed_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h1000),
              mk_result(ST_GUESS, 10'd0, '0, '0, 1'b1, 11'd1));
    typed_row(mk_item(ACT_APPEND, 64'h1000, 64'h100, 1'b0, '0),
              mk_result(ST_APPENDED, 10'd1, 64'h1000, 64'h100, 1'b0, 11'd2));
    // equal start is accepted, lower start is refused
    typed_row(mk_item(ACT_APPEND, 64'h1000, 64'h10, 1'b1, '0),
              mk_result(ST_APPENDED, 10'd2, 64'h1000, 64'h10, 1'b1, 11'd3));
    typed_row(mk_item(ACT_APPEND, 64'hFFF, 64'h5, 1'b0, '0),
              mk_result(ST_REJECTED, '0, '0, '0, 1'b0, 11'd3));
    // cover found past a non-covering duplicate; end of range misses
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h1050));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h1100));
    // zero-length data object is never a guess
    model_row(mk_item(ACT_APPEND, 64'h2000, '0, 1'b0, '0));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h2000));
    // top of the address space, maximum length
    model_row(mk_item(ACT_APPEND, MAX64 - 64'hF, MAX64, 1'b1, '0));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, MAX64));
    model_row(mk_item(ACT_APPEND, MAX64, 64'h1, 1'b0, '0));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, MAX64));
    typed_row(mk_item(ACT_APPEND, '0, 64'h1, 1'b1, '0),
              mk_result(ST_REJECTED, '0, '0, '0, 1'b0, 11'd6));
    typed_row(mk_item(ACT_CLEAR, MAX64, MAX64, 1'b1, MAX64),
              mk_result(ST_CLEARED, '0, '0, '0, 1'b0, 11'd0));
    typed_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, MAX64),
              mk_result(ST_NOTFOUND, '0, '0, '0, 1'b0, 11'd0));
    typed_row(mk_item(ACT_APPEND, MAX64, MAX64, 1'b0, '0),
              mk_result(ST_APPENDED, 10'd0, MAX64, MAX64, 1'b0, 11'd1));
    // address below the first entry
    typed_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, '0),
              mk_result(ST_NOTFOUND, '0, '0, '0, 1'b0, 11'd1));
    typed_row(mk_item(ACT_APPEND, 64'h5, 64'h5, 1'b1, '0),
              mk_result(ST_REJECTED, '0, '0, '0, 1'b0, 11'd1));
    typed_row(mk_item(ACT_CLEAR, '0, '0, 1'b0, '0),
              mk_result(ST_CLEARED, '0, '0, '0, 1'b0, 11'd0));
    // last byte of a range and the byte just past it
    model_row(mk_item(ACT_APPEND, 64'h10, 64'h20, 1'b1, '0));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h2F));
    model_row(mk_item(ACT_LOOKUP, '0, '0, 1'b0, 64'h30));

    foreach (dir_table[i]) drive_item(dir_table[i].stim, dir_table[i].typed,
                                      dir_table[i].want);

    // ---- random part ----
    random_base = items_sent;
    mixed = 0;
    while (mixed < RANDOM_ITEMS) begin
      // idling switches on and off per sequence; none near the end
      idle_mode = (RANDOM_ITEMS - mixed > QUIET_TAIL) && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          // well-formed: optional clear, in-order appends, then lookups
          if ($urandom_range(0, 1)) send_clear();
          n = ($urandom_range(0, 6) == 0) ? $urandom_range(33, 90) : $urandom_range(1, 12);
          repeat (n) send_append(pick_length(), 1'($urandom_range(0, 1)));
          repeat ($urandom_range(2, 10)) send_lookup();
        end
        6: begin
          // one zero-length function, then a run of zero-length data objects:
          // the guess is reachable only while the run is shorter than the scan
          send_clear();
          send_append('0, 1'b1);
          repeat ($urandom_range(SCAN_DEPTH - 2, SCAN_DEPTH + 8)) send_append('0, 1'b0);
          drive_item(mk_item(ACT_LOOKUP, '0, '0, 1'b0,
                             tbl_start[tbl_count-1] + ADDR_W'($urandom_range(0, 3))),
                     1'b0, '0);
          send_lookup();
        end
        7: begin
          // out-of-order append
          below = (tbl_count > 0) ?
                  tbl_start[tbl_count-1] - ADDR_W'($urandom_range(1, 100)) : rand64();
          drive_item(mk_item(ACT_APPEND, below, pick_length(), 1'($urandom_range(0, 1)),
                             rand64()), 1'b0, '0);
          send_lookup();
        end
        8: begin
          drive_item(mk_item(ACT_UNUSED, rand64(), rand64(), 1'($urandom_range(0, 1)),
                             rand64()), 1'b0, '0);
        end
        default: begin
          // raw noise: any action, any fields
          drive_item(mk_item(ACTION_W'($urandom_range(0, 3)), rand64(), rand64(),
                             1'($urandom_range(0, 1)), rand64()), 1'b0, '0);
        end
      endcase
      mixed = items_sent - random_base;
    end

    // ---- drain ----
    idle_mode = 1'b0;
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d appended, %0d refused, %0d clears",
             items_sent, outcome_tally[ST_APPENDED], outcome_tally[ST_REJECTED],
             outcome_tally[ST_CLEARED]);
    $display("Lookups and unused codes: %0d covered, %0d guessed, %0d not found",
             outcome_tally[ST_HIT], outcome_tally[ST_GUESS], outcome_tally[ST_NOTFOUND]);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
design/arsl_pkg.sv
design/arsl_ram.sv
design/address_range_symbol_lookup_top.sv
tb/sv/address_range_symbol_lookup_top_test.sv
